// File: rtl/core/prf_pkg.sv
package prf_pkg;

   // frame store geometry
   localparam int ROW_BYTES   = 80;
   localparam int ROWS        = 480;
   localparam int STORE_WORDS = ROW_BYTES * ROWS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int PLANES      = 4;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = PLANES * BYTE_W;

   // transaction field widths
   localparam int CMD_W       = 2;
   localparam int POS_W       = 12;
   localparam int COLOR_W     = PLANES;
   localparam int INDEX_W     = 16;

   // register port
   localparam int CLIP_W_W    = 10;
   localparam int CLIP_H_W    = 9;
   localparam int CSR_DATA_W  = CLIP_W_W;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CLIP_W_W-1:0] CLIP_WIDTH_RESET  = CLIP_W_W'(640);
   localparam logic [CLIP_H_W-1:0] CLIP_HEIGHT_RESET = CLIP_H_W'(480);

   // internal coordinate widths: span ends reach twice the field range
   localparam int COORD_W     = POS_W + 2;
   localparam int COL_W       = COORD_W - 3;
   localparam int IDX_W       = COORD_W + $clog2(ROW_BYTES) + 2;

   localparam logic [BYTE_W-1:0] BYTE_ALL = '1;
   localparam logic signed [IDX_W-1:0] ROW_STEP    = IDX_W'(ROW_BYTES);
   localparam logic signed [IDX_W-1:0] STORE_LIMIT = IDX_W'(STORE_WORDS);

   typedef enum logic [CMD_W-1:0] {
      CMD_FILL      = 2'd0,
      CMD_FILL_CLIP = 2'd1,
      CMD_READ      = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLIP_WIDTH  = 1'd0,
      CSR_CLIP_HEIGHT = 1'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLIP_X,
      ST_CLIP_Y,
      ST_SETUP,
      ST_ROW,
      ST_WORD,
      ST_MERGE,
      ST_READ,
      ST_RESPOND
   } state_type;

   // start and exclusive end of a span along one axis
   typedef struct packed {
      logic signed [COORD_W-1:0] first;
      logic signed [COORD_W-1:0] last;
   } span_type;

   // span of one axis, optionally clipped to [0, limit)
   function automatic span_type clip_span(input logic signed [POS_W-1:0] pos,
                                          input logic signed [POS_W-1:0] len,
                                          input logic [CLIP_W_W-1:0] limit,
                                          input logic clipped);
      logic signed [COORD_W-1:0] p;
      logic signed [COORD_W-1:0] e;
      logic signed [COORD_W-1:0] lim;
      span_type r;
      p   = {{(COORD_W-POS_W){pos[POS_W-1]}}, pos};
      e   = p + {{(COORD_W-POS_W){len[POS_W-1]}}, len};
      lim = {{(COORD_W-CLIP_W_W){1'b0}}, limit};
      r.first = p;
      r.last  = e;
      if (clipped) begin
         if (p < 0) r.first = '0;
         if (e > lim) r.last = lim;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/prf_ram.sv
module prf_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/planar_rect_fill.sv
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+-------------------------
// command   | start, busy, req_cmd .. req_read_index       | start && !busy
// result    | rsp_strobe, rsp_read_word, rsp_nothing_drawn | strobe, one cycle, no hold
// registers | csr_write_enable, csr_index, csr_write_data  | write enable, no wait
//
// after reset a clearing pass writes every frame store word with busy high;
// register writes are taken meanwhile
// a fill clips x, then y, sets up, and walks each row; each word written is read
// then written through the single frame store memory, a word masked or dropped is
// skipped; a read passes ST_READ and an unused command goes straight to ST_RESPOND
// the registered result is shown for one cycle only and cannot be held off
module planar_rect_fill (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [prf_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [prf_pkg::POS_W-1:0]    req_x_pos,
   input  logic signed [prf_pkg::POS_W-1:0]    req_y_pos,
   input  logic signed [prf_pkg::POS_W-1:0]    req_rect_width,
   input  logic signed [prf_pkg::POS_W-1:0]    req_rect_height,
   input  logic [prf_pkg::COLOR_W-1:0]         req_fill_color,
   input  logic [prf_pkg::INDEX_W-1:0]         req_read_index,
   output logic                                rsp_strobe,
   output logic [prf_pkg::WORD_W-1:0]          rsp_read_word,
   output logic                                rsp_nothing_drawn,
   input  logic                                csr_write_enable,
   input  logic [prf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [prf_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import prf_pkg::*;

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clear_cnt_ff, clear_cnt_in;
   cmd_type                   cmd_ff, cmd_in;
   logic signed [POS_W-1:0]   x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic [INDEX_W-1:0]        read_index_ff, read_index_in;
   logic [CLIP_W_W-1:0]       clip_width_ff, clip_width_in;
   logic [CLIP_H_W-1:0]       clip_height_ff, clip_height_in;
   logic signed [COORD_W-1:0] xs_ff, xs_in, xe_ff, xe_in, ys_ff, ys_in, ye_ff, ye_in;
   logic signed [COORD_W-1:0] row_ff, row_in;
   logic signed [IDX_W-1:0]   rowbase_ff, rowbase_in;
   logic signed [COL_W-1:0]   col_ff, col_in;
   logic signed [IDX_W-1:0]   idx_ff, idx_in;
   logic                      nothing_ff, nothing_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [WORD_W-1:0]         rsp_word_ff, rsp_word_in;
   logic                      rsp_nothing_ff, rsp_nothing_in;

   span_type                  span;
   logic signed [COL_W-1:0]   lb, rb;
   logic [2:0]                lo, ro;
   logic [BYTE_W-1:0]         mask;
   logic [WORD_W-1:0]         mask_word, color_word, merged;
   logic                      last_col, row_done, idx_ok, word_live, read_ok;
   logic                      clear_done, empty, advance;
   logic signed [COORD_W-1:0] row_next;

   logic                      ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]         ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]         ram_wr_data, ram_rd_data;

   prf_ram #(
      .DATA_W (WORD_W),
      .DEPTH  (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared clipping unit, x axis then y axis
   always_comb begin
      if (state_ff == ST_CLIP_Y) begin
         span = clip_span(y_ff, h_ff, {1'b0, clip_height_ff}, cmd_ff == CMD_FILL_CLIP);
      end else begin
         span = clip_span(x_ff, w_ff, clip_width_ff, cmd_ff == CMD_FILL_CLIP);
      end
   end

   // edge byte columns and pixel offsets
   assign lb = xs_ff[COORD_W-1:3];
   assign lo = xs_ff[2:0];
   assign rb = xe_ff[COORD_W-1:3];
   assign ro = xe_ff[2:0];

   // edge masks for the current column
   always_comb begin
      mask = BYTE_ALL;
      if (col_ff == lb) mask = mask & (BYTE_ALL >> lo);
      if (col_ff == rb) mask = mask & ~(BYTE_ALL >> ro);
   end

   // plane merge
   always_comb begin
      for (int k = 0; k < PLANES; k++) begin
         color_word[k*BYTE_W +: BYTE_W] = {BYTE_W{color_ff[k]}};
      end
      mask_word = {PLANES{mask}};
      merged    = (ram_rd_data & ~mask_word) | (color_word & mask_word);
   end

   // status of the walk over the rectangle
   assign last_col   = (col_ff == rb);
   assign row_next   = row_ff + COORD_W'(1);
   assign row_done   = (row_next == ye_ff);
   assign idx_ok     = (idx_ff >= 0) && (idx_ff < STORE_LIMIT);
   assign word_live  = (mask != '0) && idx_ok;
   assign read_ok    = 32'(read_index_ff) < 32'(STORE_WORDS);
   assign clear_done = (clear_cnt_ff == ADDR_W'(STORE_WORDS - 1));
   assign empty      = (xe_ff <= xs_ff) || (ye_ff <= ys_ff);
   assign advance    = (state_ff == ST_MERGE) || ((state_ff == ST_WORD) && !word_live);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_FILL, CMD_FILL_CLIP: state_in = ST_CLIP_X;
                  CMD_READ:                state_in = ST_READ;
                  default:                 state_in = ST_RESPOND;
               endcase
            end
         end
         ST_CLIP_X: state_in = ST_CLIP_Y;
         ST_CLIP_Y: state_in = ST_SETUP;
         ST_SETUP: begin
            state_in = empty ? ST_RESPOND : ST_ROW;
         end
         ST_ROW:  state_in = ST_WORD;
         ST_WORD, ST_MERGE: begin
            if ((state_ff == ST_WORD) && word_live) begin
               state_in = ST_MERGE;
            end else if (last_col) begin
               state_in = row_done ? ST_RESPOND : ST_ROW;
            end else begin
               state_in = ST_WORD;
            end
         end
         ST_READ:    state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // datapath registers
   always_comb begin
      clear_cnt_in   = clear_cnt_ff;
      cmd_in         = cmd_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      w_in           = w_ff;
      h_in           = h_ff;
      color_in       = color_ff;
      read_index_in  = read_index_ff;
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;
      xs_in          = xs_ff;
      xe_in          = xe_ff;
      ys_in          = ys_ff;
      ye_in          = ye_ff;
      row_in         = row_ff;
      rowbase_in     = rowbase_ff;
      col_in         = col_ff;
      idx_in         = idx_ff;
      nothing_in     = nothing_ff;
      rsp_strobe_in  = 1'b0;
      rsp_word_in    = rsp_word_ff;
      rsp_nothing_in = rsp_nothing_ff;

      // register writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CLIP_WIDTH:  clip_width_in  = csr_write_data[CLIP_W_W-1:0];
            CSR_CLIP_HEIGHT: clip_height_in = csr_write_data[CLIP_H_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
         ST_IDLE: begin
            if (start) begin
               cmd_in        = cmd_type'(req_cmd);
               x_in          = req_x_pos;
               y_in          = req_y_pos;
               w_in          = req_rect_width;
               h_in          = req_rect_height;
               color_in      = req_fill_color;
               read_index_in = req_read_index;
               nothing_in    = 1'b0;
            end
         end
         ST_CLIP_X: begin
            xs_in = span.first;
            xe_in = span.last;
         end
         ST_CLIP_Y: begin
            ys_in = span.first;
            ye_in = span.last;
         end
         ST_SETUP: begin
            row_in     = ys_ff;
            rowbase_in = $signed({{(IDX_W-COORD_W){ys_ff[COORD_W-1]}}, ys_ff}) * ROW_STEP;
            nothing_in = empty && (cmd_ff == CMD_FILL_CLIP);
         end
         ST_ROW: begin
            col_in = lb;
            idx_in = rowbase_ff + {{(IDX_W-COL_W){lb[COL_W-1]}}, lb};
         end
         ST_RESPOND: begin
            rsp_strobe_in  = 1'b1;
            rsp_word_in    = ((cmd_ff == CMD_READ) && read_ok) ? ram_rd_data : '0;
            rsp_nothing_in = nothing_ff;
         end
         default: ;
      endcase

      // step to the next word or the next row
      if (advance) begin
         if (last_col) begin
            row_in     = row_next;
            rowbase_in = rowbase_ff + ROW_STEP;
         end else begin
            col_in = col_ff + COL_W'(1);
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   // memory controls
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[ADDR_W-1:0];
      ram_wr_data = merged;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[ADDR_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_cnt_ff;
            ram_wr_data = '0;
         end
         ST_WORD:  ram_rd_en = word_live;
         ST_MERGE: ram_wr_en = 1'b1;
         ST_READ: begin
            ram_rd_en   = read_ok;
            ram_rd_addr = ADDR_W'(read_index_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_cnt_ff   <= '0;
         clip_width_ff  <= CLIP_WIDTH_RESET;
         clip_height_ff <= CLIP_HEIGHT_RESET;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_cnt_ff   <= clear_cnt_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      w_ff           <= w_in;
      h_ff           <= h_in;
      color_ff       <= color_in;
      read_index_ff  <= read_index_in;
      xs_ff          <= xs_in;
      xe_ff          <= xe_in;
      ys_ff          <= ys_in;
      ye_ff          <= ye_in;
      row_ff         <= row_in;
      rowbase_ff     <= rowbase_in;
      col_ff         <= col_in;
      idx_ff         <= idx_in;
      nothing_ff     <= nothing_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_nothing_ff <= rsp_nothing_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_word     = rsp_word_ff;
   assign rsp_nothing_drawn = rsp_nothing_ff;

`ifndef SYNTH
   // a result is shown for a single cycle per transaction
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // read-modify-write never overlaps its own read and write
   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("frame store read and written in the same cycle");

   // dropped words never reach the store
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (32'(ram_wr_addr) < 32'(STORE_WORDS)))
      else $error("frame store write outside the store");

   // an empty clipped fill answers with a zero word
   a_nothing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_nothing_drawn) |-> (rsp_read_word == '0))
      else $error("empty fill answered with a nonzero word");
`endif

endmodule
